// ----- sv/rgha_pkg.sv -----
// Shared constants, types and pixel/glyph functions for the gray half-size ASCII art unit.
package rgha_pkg;

   localparam int DEF_MAX_WIDTH  = 64;
   localparam int DEF_MAX_HEIGHT = 64;
   localparam int GLYPH_LEVELS   = 16;

   localparam int COMP_WIDTH   = 8;   // one colour component
   localparam int QUARTER_W    = 6;   // gray >> 2
   localparam int PAIR_W       = 7;   // sum of two quarters
   localparam int SUM_W        = 8;   // sum of four quarters
   localparam int GLYPH_W      = 7;
   localparam int LEVEL_W      = $clog2(GLYPH_LEVELS);
   localparam int CSR_WIDTH    = 7;
   localparam int CSR_INDEX_W  = 1;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 8;

   localparam logic [CSR_WIDTH-1:0] FRAME_WIDTH_RESET  = 7'd32;
   localparam logic [CSR_WIDTH-1:0] FRAME_HEIGHT_RESET = 7'd32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;

   // Luma with weights 5/16, 9/16 and 2/16, then truncated to a quarter.
   function automatic logic [QUARTER_W-1:0] gray_quarter(input req_data_type pix);
      logic [11:0] acc;
      acc = 12'(pix[7:0]) * 12'd5 + 12'(pix[15:8]) * 12'd9 + {3'd0, pix[23:16], 1'b0};
      return acc[11:6];
   endfunction

   // sum * 15 / 255 equals sum / 17; for sums below 256, (sum * 241) >> 12 is exact.
   function automatic logic [LEVEL_W-1:0] glyph_level(input logic [SUM_W-1:0] sum);
      logic [15:0] prod;
      prod = 16'(sum) * 16'd241;
      return prod[15:12];
   endfunction

   function automatic logic [GLYPH_W-1:0] glyph_code(input logic [LEVEL_W-1:0] level);
      logic [GLYPH_W-1:0] code;
      case (level)
         4'd0:    code = 7'd32;   // space
         4'd1:    code = 7'd46;   // .
         4'd2:    code = 7'd58;   // :
         4'd3:    code = 7'd45;   // -
         4'd4:    code = 7'd61;   // =
         4'd5:    code = 7'd43;   // +
         4'd6:    code = 7'd47;   // /
         4'd7:    code = 7'd116;  // t
         4'd8:    code = 7'd122;  // z
         4'd9:    code = 7'd85;   // U
         4'd10:   code = 7'd119;  // w
         4'd11:   code = 7'd42;   // *
         4'd12:   code = 7'd48;   // 0
         4'd13:   code = 7'd35;   // #
         4'd14:   code = 7'd37;   // %
         default: code = 7'd64;   // @
      endcase
      return code;
   endfunction

endpackage

// ----- sv/rgha_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rgha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rgb_gray_halfsize_ascii_art_unit.sv -----
// Top level: RGB pixel stream to 2x2-downscaled ASCII art glyph stream.
//
//   Channel   Direction  Handshake                 Payload
//   req_      in         req_tvalid / req_tready   tdata: red, green, blue
//   rsp_      out        rsp_tvalid / rsp_tready   tdata: glyph; tlast: row_end;
//                                                  tuser: frame_end
//   csr_      in         csr_wr_en (no wait)       csr_index, csr_wr_data
//
// One pixel is accepted per clock while the result side keeps up. A glyph reaches
// rsp_ once the pixel completing its 2x2 block has passed the registered read of
// the line store and the glyph lookup into the output register. A stall on the
// result side fills the two stages and then holds req_tready low. Reset clears
// the position counters, the pipeline valids and the frame size registers; the
// line store needs no clearing pass since every entry is written before it is read.
module rgb_gray_halfsize_ascii_art_unit
   #(
   parameter int MAX_WIDTH  = rgha_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rgha_pkg::DEF_MAX_HEIGHT
) (
   input  logic                         clock,
   input  logic                         reset,
   // Pixel transactions
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  rgha_pkg::req_data_type       req_tdata,   // [7:0] red, [15:8] green, [23:16] blue
   // Glyph transactions
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output rgha_pkg::rsp_data_type       rsp_tdata,   // [6:0] glyph, [7] zero
   output logic                         rsp_tlast,   // row_end
   output logic                         rsp_tuser,   // [0] frame_end
   // Frame size registers
   input  logic                         csr_wr_en,
   input  logic [rgha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rgha_pkg::CSR_WIDTH-1:0]   csr_wr_data
);

   import rgha_pkg::*;

   // Widths for counters, effective sizes and the half-width line store.
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WCLOG    = $clog2(MAX_WIDTH + 1);
   localparam int HCLOG    = $clog2(MAX_HEIGHT + 1);
   localparam int WSIZE_W  = (WCLOG > CSR_WIDTH) ? WCLOG : CSR_WIDTH;
   localparam int HSIZE_W  = (HCLOG > CSR_WIDTH) ? HCLOG : CSR_WIDTH;
   localparam int STORE_DEPTH = MAX_WIDTH / 2;
   localparam int SLOT_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   // Frame size registers, kept raw and saturated when used.
   logic [CSR_WIDTH-1:0] frame_width_ff, frame_width_in;
   logic [CSR_WIDTH-1:0] frame_height_ff, frame_height_in;

   // Position and even-column state.
   logic [COL_W-1:0]     col_ff, col_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic [QUARTER_W-1:0] left_quarter_ff, left_quarter_in;

   // Stage one: waits for the line store read.
   logic                 s1_valid_ff, s1_valid_in;
   logic [PAIR_W-1:0]    s1_pair_ff, s1_pair_in;
   logic                 s1_row_end_ff, s1_row_end_in;
   logic                 s1_frame_end_ff, s1_frame_end_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_W-1:0]   rsp_glyph_ff, rsp_glyph_in;
   logic                 rsp_row_end_ff, rsp_row_end_in;
   logic                 rsp_frame_end_ff, rsp_frame_end_in;

   logic [WSIZE_W-1:0]   width_eff;
   logic [HSIZE_W-1:0]   height_eff;
   logic [WSIZE_W-1:0]   col_ext;
   logic [HSIZE_W-1:0]   row_ext;
   logic                 accept;
   logic                 s1_adv;
   logic [QUARTER_W-1:0] quarter;
   logic [PAIR_W-1:0]    pair_sum;
   logic                 in_range;
   logic                 store_wr;
   logic                 emit;
   logic [SLOT_W-1:0]    slot;
   logic [PAIR_W-1:0]    upper_pair;
   logic [SUM_W-1:0]     block_sum;
   logic                 last_col;
   logic                 last_row;

   // Out-of-range sizes are saturated into 2..MAX.
   always_comb begin
      width_eff = WSIZE_W'(frame_width_ff);
      if (width_eff < WSIZE_W'(2)) begin
         width_eff = WSIZE_W'(2);
      end else if (width_eff > WSIZE_W'(MAX_WIDTH)) begin
         width_eff = WSIZE_W'(MAX_WIDTH);
      end
      height_eff = HSIZE_W'(frame_height_ff);
      if (height_eff < HSIZE_W'(2)) begin
         height_eff = HSIZE_W'(2);
      end else if (height_eff > HSIZE_W'(MAX_HEIGHT)) begin
         height_eff = HSIZE_W'(MAX_HEIGHT);
      end
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_wr_data;
            CSR_FRAME_HEIGHT: frame_height_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   // The output register takes stage one whenever it is empty or being drained,
   // and stage one takes a new pixel whenever it is empty or moving on.
   assign s1_adv     = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   assign col_ext  = WSIZE_W'(col_ff);
   assign row_ext  = HSIZE_W'(row_ff);
   assign quarter  = gray_quarter(req_tdata);
   assign pair_sum = PAIR_W'(left_quarter_ff) + PAIR_W'(quarter);
   assign slot     = SLOT_W'(col_ff >> 1);

   // Only odd columns inside the frame finish a pair. A counter beyond a shrunken size
   // produces nothing; a column wraps at the next pixel, a row at the end of that row.
   assign in_range = col_ff[0] && (col_ext < width_eff) && (row_ext < height_eff);
   assign store_wr = accept && in_range && !row_ff[0];
   assign emit     = accept && in_range && row_ff[0];

   // Row end sits on the last odd column; a trailing odd column is dropped.
   assign last_col = (col_ext == ((width_eff & ~WSIZE_W'(1)) - WSIZE_W'(1)));
   assign last_row = (row_ext == ((height_eff & ~HSIZE_W'(1)) - HSIZE_W'(1)));

   // Pair sums of the even row, one entry per output column. The odd row reads
   // the entry when its pixel is accepted; the write for that entry happened a
   // full input row earlier, so no bypass is needed.
   rgha_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (STORE_DEPTH),
      .ADDR_W(SLOT_W)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (store_wr),
      .wr_addr(slot),
      .wr_data(pair_sum),
      .rd_en  (emit),
      .rd_addr(slot),
      .rd_data(upper_pair)
   );

   // Position counters and the even-column quarter.
   always_comb begin
      col_in          = col_ff;
      row_in          = row_ff;
      left_quarter_in = left_quarter_ff;
      if (accept) begin
         if (!col_ff[0]) begin
            left_quarter_in = quarter;
         end
         if (col_ext + WSIZE_W'(1) >= width_eff) begin
            col_in = '0;
            if (row_ext + HSIZE_W'(1) >= height_eff) begin
               row_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   // Stage one holds the lower pair and the marks until the store data arrives.
   always_comb begin
      s1_valid_in     = s1_valid_ff;
      s1_pair_in      = s1_pair_ff;
      s1_row_end_in   = s1_row_end_ff;
      s1_frame_end_in = s1_frame_end_ff;
      if (accept) begin
         s1_valid_in = emit;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      if (emit) begin
         s1_pair_in      = pair_sum;
         s1_row_end_in   = last_col;
         s1_frame_end_in = last_col && last_row;
      end
   end

   assign block_sum = SUM_W'(upper_pair) + SUM_W'(s1_pair_ff);

   always_comb begin
      rsp_valid_in     = rsp_valid_ff;
      rsp_glyph_in     = rsp_glyph_ff;
      rsp_row_end_in   = rsp_row_end_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (s1_adv) begin
         rsp_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            rsp_glyph_in     = glyph_code(glyph_level(block_sum));
            rsp_row_end_in   = s1_row_end_ff;
            rsp_frame_end_in = s1_frame_end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         left_quarter_ff <= '0;
         s1_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         left_quarter_ff <= left_quarter_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pair_ff       <= s1_pair_in;
      s1_row_end_ff    <= s1_row_end_in;
      s1_frame_end_ff  <= s1_frame_end_in;
      rsp_glyph_ff     <= rsp_glyph_in;
      rsp_row_end_ff   <= rsp_row_end_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_glyph_ff};
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_frame_end_ff;

endmodule

// ----- sim/glyph_scoreboard_pkg.sv -----
// Glyph predictor and scoreboard for the gray half-size ASCII art unit testbench.
`timescale 1ns / 100ps
package glyph_scoreboard_pkg;
   import rgha_pkg::*;

   localparam int unsigned PAIR_SLOTS = DEF_MAX_WIDTH / 2;

   typedef struct packed {
      logic [GLYPH_W-1:0] glyph;
      logic               row_end;
      logic               frame_end;
   } glyph_item_type;

   class glyph_scoreboard;
      logic [CSR_WIDTH-1:0] width_reg;
      logic [CSR_WIDTH-1:0] height_reg;
      int unsigned          col_pos;
      int unsigned          row_pos;
      int unsigned          left_quarter;
      int unsigned          pair_sums [PAIR_SLOTS];
      string                art_chars = " .:-=+/tzUw*0#%@";
      glyph_item_type       pending_glyphs [$];
      int unsigned          mismatches;

      function new();
         width_reg    = FRAME_WIDTH_RESET;
         height_reg   = FRAME_HEIGHT_RESET;
         col_pos      = 0;
         row_pos      = 0;
         left_quarter = 0;
         mismatches   = 0;
         foreach (pair_sums[i]) pair_sums[i] = 0;
      endfunction

      // Size as the block uses it: out-of-range values saturate into 2..hi.
      static function int unsigned used_size(logic [CSR_WIDTH-1:0] value, int unsigned hi);
         if (value < 2) return 2;
         if (value > hi) return hi;
         return value;
      endfunction

      function int unsigned eff_width();
         return used_size(width_reg, DEF_MAX_WIDTH);
      endfunction

      function int unsigned eff_height();
         return used_size(height_reg, DEF_MAX_HEIGHT);
      endfunction

      function void write_reg(csr_index_type idx, logic [CSR_WIDTH-1:0] value);
         case (idx)
            CSR_FRAME_WIDTH:  width_reg = value;
            CSR_FRAME_HEIGHT: height_reg = value;
            default: ;
         endcase
      endfunction

      // Advances the predicted position by one pixel and queues the glyph it completes.
      function void note_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         int unsigned    w;
         int unsigned    h;
         int unsigned    gray;
         int unsigned    quarter;
         int unsigned    pair;
         int unsigned    sum;
         int unsigned    level;
         glyph_item_type item;
         w       = eff_width();
         h       = eff_height();
         gray    = (5 * red + 9 * green + 2 * blue) >> 4;
         quarter = gray >> 2;
         if (col_pos % 2 == 0) begin
            left_quarter = quarter;
         end else if (col_pos < w && row_pos < h && col_pos / 2 < PAIR_SLOTS) begin
            pair = left_quarter + quarter;
            if (row_pos % 2 == 0) begin
               pair_sums[col_pos / 2] = pair;
            end else begin
               sum   = pair_sums[col_pos / 2] + pair;
               level = sum * (GLYPH_LEVELS - 1) / 255;
               if (level >= GLYPH_LEVELS) level = GLYPH_LEVELS - 1;
               item.glyph     = 7'(art_chars[level]);
               item.row_end   = (col_pos == (w / 2) * 2 - 1);
               item.frame_end = item.row_end && (row_pos == (h / 2) * 2 - 1);
               pending_glyphs.push_back(item);
            end
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos = col_pos + 1;
         end
      endfunction

      task report(string msg);
         $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_glyph(logic [RSP_DATA_W-1:0] data, logic last, logic user);
         glyph_item_type want;
         if (pending_glyphs.size() == 0) begin
            report($sformatf("glyph 0x%02h arrived with none expected", data));
            return;
         end
         want = pending_glyphs.pop_front();
         if (data[GLYPH_W-1:0] !== want.glyph)
            report($sformatf("glyph 0x%02h, expected 0x%02h", data[GLYPH_W-1:0], want.glyph));
         if (data[RSP_DATA_W-1:GLYPH_W] !== '0)
            report($sformatf("padding bits of glyph data are %b", data[RSP_DATA_W-1:GLYPH_W]));
         if (last !== want.row_end)
            report($sformatf("row_end %b, expected %b", last, want.row_end));
         if (user !== want.frame_end)
            report($sformatf("frame_end %b, expected %b", user, want.frame_end));
      endtask
   endclass

endpackage

// ----- sim/tb.sv -----
// Testbench top level for the gray half-size ASCII art unit.
`timescale 1ns / 100ps
module tb;
   import rgha_pkg::*;
   import glyph_scoreboard_pkg::*;

   // The run is short; this limit is many times the slowest legal run.
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // Margin after the last expected glyph, to cover pixels that emit nothing.
   localparam int unsigned DRAIN_CYCLES = 6;
   localparam int unsigned RANDOM_ITEMS = 800;
   localparam int unsigned PHASES       = 4;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   req_data_type           req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   rsp_data_type           rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_WIDTH-1:0]   csr_wr_data = '0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned cycle_count    = 0;
   int unsigned pixels_sent    = 0;

   glyph_scoreboard glyphs;

   rgb_gray_halfsize_ascii_art_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rgb_gray_halfsize_ascii_art_unit test failed");
         $finish;
      end
   end

   // Result side. Outputs are sampled at the edge, before the block updates them, so each
   // glyph transaction is checked exactly when it is accepted. The ready line stalls at
   // random according to the current phase.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         glyphs.check_glyph(rsp_tdata, rsp_tlast, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Offers one pixel, after a random idle gap, and holds it until the block takes it.
   // Valid is only lowered when a gap is inserted, so it never toggles within one step.
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
      int unsigned gap = 0;
      while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {blue, green, red};
      do @(posedge clock); while (!req_tready);
      glyphs.note_pixel(red, green, blue);
      pixels_sent++;
   endtask

   // Stops offering pixels and waits until every expected glyph has come out, then a few
   // more cycles in case the last pixels were ones that produce no glyph.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (glyphs.pending_glyphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The register port has no handshake: one edge with the enable high is one write.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_WIDTH-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      glyphs.write_reg(idx, value);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic write_frame_size(input logic [CSR_WIDTH-1:0] w,
                                   input logic [CSR_WIDTH-1:0] h);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
   endtask

   // Colour components lean towards the extremes so that black and white areas occur.
   function automatic logic [7:0] random_level();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Mostly small even sizes, with odd sizes, values that saturate low, the largest
   // legal size and values that saturate high mixed in.
   function automatic logic [CSR_WIDTH-1:0] random_size();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) return 7'(2 * $urandom_range(1, 6));
      if (pick < 75) return 7'(2 * $urandom_range(1, 6) + 1);
      if (pick < 85) return 7'($urandom_range(1));
      if (pick < 92) return 7'd64;
      return 7'($urandom_range(65, 127));
   endfunction

   // One whole frame of random pixels at the current size; the position counters are
   // back at the top left corner when it is done.
   task automatic send_frame();
      int unsigned count;
      count = glyphs.eff_width() * glyphs.eff_height();
      repeat (count) send_pixel(random_level(), random_level(), random_level());
   endtask

   initial begin
      logic [CSR_WIDTH-1:0] w;
      logic [CSR_WIDTH-1:0] h;
      int unsigned          phase_target;
      glyphs = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Width 4 with the height left at its reset value: two rows give two glyphs, the
      // second one closing the output row but not the frame. Primary colours and white
      // exercise each weight of the gray sum on its own.
      write_csr(CSR_FRAME_WIDTH, 7'd4);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h00, 8'hFF, 8'h00);
      send_pixel(8'h00, 8'h00, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h80, 8'h40, 8'h20);
      send_pixel(8'h7F, 8'hC0, 8'hFF);

      // Shrinking the height mid-frame leaves the row counter beyond the new size: that
      // row produces nothing and wraps to the top of the next frame.
      drain();
      write_csr(CSR_FRAME_HEIGHT, 7'd2);
      repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);

      // Smallest frame, back to back: all white gives the densest reachable glyph (%), all
      // black the blank one, each marked as both row end and frame end.
      drain();
      write_csr(CSR_FRAME_WIDTH, 7'd2);
      repeat (4) send_pixel(8'hFF, 8'hFF, 8'hFF);
      repeat (4) send_pixel(8'h00, 8'h00, 8'h00);
      drain();

      // Random frames in phases of different idling on the two sides. The first frame
      // uses register values that saturate at both ends.
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (phase == 0) begin
            write_frame_size(7'd127, 7'd0);
            send_frame();
         end
         // The pixel budget counts from the start of the run, directed pixels included.
         phase_target = (phase + 1) * RANDOM_ITEMS / PHASES;
         while (pixels_sent < phase_target) begin
            // Half the frames follow on directly at the same size, so that frames meet
            // without a pause; the others change the size once the block is idle.
            if ($urandom_range(1) == 1) begin
               drain();
               w = random_size();
               h = random_size();
               if (glyph_scoreboard::used_size(w, DEF_MAX_WIDTH) *
                   glyph_scoreboard::used_size(h, DEF_MAX_HEIGHT) > 256) begin
                  if ($urandom_range(1) == 1) h = 7'(2 + $urandom_range(1));
                  else                        w = 7'(2 + $urandom_range(1));
               end
               write_frame_size(w, h);
            end
            send_frame();
         end
         drain();
      end

      if (glyphs.mismatches == 0) begin
         $display("rgb_gray_halfsize_ascii_art_unit test passed");
      end else begin
         $display("rgb_gray_halfsize_ascii_art_unit test failed");
      end
      $finish;
   end

endmodule

// ----- rgb_gray_halfsize_ascii_art_unit.f -----
sv/rgha_pkg.sv
sv/rgha_ram.sv
sv/rgb_gray_halfsize_ascii_art_unit.sv
sim/glyph_scoreboard_pkg.sv
sim/tb.sv
